@@ src/srr_pkg.sv @@
// srr_pkg: shared types and default constants for the selective-repeat receiver.
// No dependencies; used by every module of the block.
package srr_pkg;

    localparam int WINDOW_DEF    = 8;
    localparam int SEQ_BITS_DEF  = 4;
    localparam int DATA_BITS_DEF = 64;
    localparam int ADDR_MAX_W    = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_LOOK,
        ST_EMIT
    } state_t;

    typedef enum logic {
        KIND_ACK  = 1'b0,
        KIND_DATA = 1'b1
    } kind_t;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_MAX_W-1:0] wr_addr;
        logic                  rd_en;
        logic [ADDR_MAX_W-1:0] rd_addr;
    } mem_cmd_t;

endpackage

@@ src/srr_slot_mem.sv @@
// srr_slot_mem: payload buffer for out-of-order packets, one write and one
// registered read port. Depends on srr_pkg.
module srr_slot_mem #(
    parameter int WINDOW    = srr_pkg::WINDOW_DEF,
    parameter int DATA_BITS = srr_pkg::DATA_BITS_DEF
) (
    input  logic                 clk,
    input  srr_pkg::mem_cmd_t    cmd,
    input  logic [DATA_BITS-1:0] wr_data,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [DATA_BITS-1:0] mem [WINDOW];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr[IDX_W-1:0]] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr[IDX_W-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/srr_ctrl.sv @@
// srr_ctrl: sequencer, window state, valid marks and output register of the
// selective-repeat receiver; one shared slot-index adder. Depends on srr_pkg.
module srr_ctrl #(
    parameter int WINDOW    = srr_pkg::WINDOW_DEF,
    parameter int SEQ_BITS  = srr_pkg::SEQ_BITS_DEF,
    parameter int DATA_BITS = srr_pkg::DATA_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SEQ_BITS-1:0]   in_seq,
    input  logic                  in_ok,
    input  logic [DATA_BITS-1:0]  in_payload,
    output logic                  out_valid,
    input  logic                  out_ready,
    output srr_pkg::kind_t        out_kind,
    output logic [SEQ_BITS-1:0]   out_ack,
    output logic [DATA_BITS-1:0]  out_data,
    output logic                  out_last,
    output srr_pkg::mem_cmd_t     mem_cmd,
    output logic [DATA_BITS-1:0]  mem_wr_data,
    input  logic [DATA_BITS-1:0]  mem_rd_data
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int D_W   = $clog2(WINDOW + 1);
    localparam int SUM_W = D_W + 1;
    localparam int SW    = (SEQ_BITS > D_W) ? SEQ_BITS : D_W;

    srr_pkg::state_t       state_reg, state_next;
    logic [SEQ_BITS-1:0]   base_reg, base_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [WINDOW-1:0]     filled_reg, filled_next;
    logic [SEQ_BITS-1:0]   seq_reg, seq_next;
    logic                  ok_reg, ok_next;
    logic [DATA_BITS-1:0]  pay_reg, pay_next;
    logic [D_W-1:0]        d_reg, d_next;
    logic                  more_reg, more_next;
    logic [IDX_W-1:0]      p_reg, p_next;
    logic [DATA_BITS-1:0]  pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    srr_pkg::kind_t        out_kind_reg, out_kind_next;
    logic [SEQ_BITS-1:0]   out_ack_reg, out_ack_next;
    logic [DATA_BITS-1:0]  out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;

    logic [SEQ_BITS-1:0]   ahead;
    logic [SEQ_BITS-1:0]   behind;
    logic                  in_win;
    logic                  in_prev;
    logic [D_W-1:0]        off;
    logic [SUM_W-1:0]      sum;
    logic [IDX_W-1:0]      phys;
    logic                  out_free;
    logic [SW-1:0]         base_sum;

    assign ahead    = seq_reg - base_reg;
    assign behind   = base_reg - seq_reg;
    assign in_win   = int'(ahead) < WINDOW;
    assign in_prev  = (behind != '0) && (int'(behind) <= WINDOW);
    assign out_free = !out_valid_reg || out_ready;

    // shared slot-index unit: (head + offset) mod WINDOW
    assign off  = (state_reg == srr_pkg::ST_CLASSIFY) ? D_W'(ahead) : d_reg;
    assign sum  = SUM_W'(head_reg) + SUM_W'(off);
    assign phys = (sum >= SUM_W'(WINDOW)) ? IDX_W'(sum - SUM_W'(WINDOW)) : IDX_W'(sum);

    assign base_sum = SW'(base_reg) + SW'(d_reg);

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        head_next      = head_reg;
        filled_next    = filled_reg;
        seq_next       = seq_reg;
        ok_next        = ok_reg;
        pay_next       = pay_reg;
        d_next         = d_reg;
        more_next      = more_reg;
        p_next         = p_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_ack_next   = out_ack_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        mem_cmd        = '0;
        in_ready       = (state_reg == srr_pkg::ST_IDLE);

        case (state_reg)
            srr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    seq_next   = in_seq;
                    ok_next    = in_ok;
                    pay_next   = in_payload;
                    state_next = srr_pkg::ST_CLASSIFY;
                end
            end
            srr_pkg::ST_CLASSIFY:
            begin
                if (!ok_reg || (!in_win && !in_prev))
                begin
                    state_next = srr_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = srr_pkg::KIND_ACK;
                    out_ack_next   = seq_reg;
                    out_data_next  = '0;
                    out_last_next  = !(in_win && (ahead == '0));
                    if (in_win && (ahead != '0))
                    begin
                        mem_cmd.wr_en          = 1'b1;
                        mem_cmd.wr_addr        = srr_pkg::ADDR_MAX_W'(phys);
                        filled_next[phys]      = 1'b1;
                        state_next             = srr_pkg::ST_IDLE;
                    end
                    else if (in_win)
                    begin
                        pend_next  = pay_reg;
                        d_next     = D_W'(1);
                        state_next = srr_pkg::ST_LOOK;
                    end
                    else
                    begin
                        state_next = srr_pkg::ST_IDLE;
                    end
                end
            end
            srr_pkg::ST_LOOK:
            begin
                more_next       = (int'(d_reg) < WINDOW) && filled_reg[phys];
                p_next          = phys;
                mem_cmd.rd_en   = more_next;
                mem_cmd.rd_addr = srr_pkg::ADDR_MAX_W'(phys);
                state_next      = srr_pkg::ST_EMIT;
            end
            srr_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = srr_pkg::KIND_DATA;
                    out_ack_next   = '0;
                    out_data_next  = pend_reg;
                    out_last_next  = !more_reg;
                    if (more_reg)
                    begin
                        filled_next[p_reg] = 1'b0;
                        d_next             = d_reg + D_W'(1);
                        pend_next          = mem_rd_data;
                        state_next         = srr_pkg::ST_LOOK;
                    end
                    else
                    begin
                        head_next  = p_reg;
                        base_next  = base_sum[SEQ_BITS-1:0];
                        state_next = srr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = srr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srr_pkg::ST_IDLE;
            base_reg      <= '0;
            head_reg      <= '0;
            filled_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            head_reg      <= head_next;
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg      <= seq_next;
        ok_reg       <= ok_next;
        pay_reg      <= pay_next;
        d_reg        <= d_next;
        more_reg     <= more_next;
        p_reg        <= p_next;
        pend_reg     <= pend_next;
        out_kind_reg <= out_kind_next;
        out_ack_reg  <= out_ack_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign mem_wr_data = pay_reg;
    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_ack     = out_ack_reg;
    assign out_data    = out_data_reg;
    assign out_last    = out_last_reg;

endmodule

@@ src/selective_repeat_receiver_unit.sv @@
// selective_repeat_receiver_unit: top level of the selective-repeat ARQ receiver.
// Depends on srr_pkg, srr_slot_mem and srr_ctrl.
//
// Input stream (s_*): one packet per item. s_tuser is the checksum-ok flag;
// packets with it low are dropped. Output stream (m_*): m_tuser = 0 carries
// an acknowledgement, m_tuser = 1 a payload delivered upward; m_tlast marks
// the final output item caused by one packet. A base packet gives its ack,
// its own payload, then every buffered consecutive payload, in order.
// Sequence: a packet is accepted, then indexed and compared; the ack leaves
// through a one-entry output register. Each delivered payload then passes
// a slot lookup with registered buffer read, then an emit. s_tready is high
// only while no packet is in work. A stall on m_tready holds the output
// register and the sequencer; nothing is dropped. Reset clears the window
// base, the valid marks and the output register; buffer contents are only
// read behind a valid mark.
module selective_repeat_receiver_unit #(
    parameter int WINDOW    = srr_pkg::WINDOW_DEF,
    parameter int SEQ_BITS  = srr_pkg::SEQ_BITS_DEF,
    parameter int DATA_BITS = srr_pkg::DATA_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [((SEQ_BITS+DATA_BITS+7)/8)*8-1:0] s_tdata,  // seq_number, payload
    input  logic s_tuser,                                      // checksum_ok
    output logic m_tvalid,
    input  logic m_tready,
    output logic [((SEQ_BITS+DATA_BITS+7)/8)*8-1:0] m_tdata,  // ack_number, data
    output logic m_tuser,                                      // kind
    output logic m_tlast                                       // last
);

    localparam int TD_W = ((SEQ_BITS + DATA_BITS + 7) / 8) * 8;

    srr_pkg::mem_cmd_t    mem_cmd;
    logic [DATA_BITS-1:0] mem_wr_data;
    logic [DATA_BITS-1:0] mem_rd_data;
    srr_pkg::kind_t       out_kind;
    logic [SEQ_BITS-1:0]  out_ack;
    logic [DATA_BITS-1:0] out_data;

    srr_ctrl #(
        .WINDOW    (WINDOW),
        .SEQ_BITS  (SEQ_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_seq      (s_tdata[SEQ_BITS-1:0]),
        .in_ok       (s_tuser),
        .in_payload  (s_tdata[SEQ_BITS +: DATA_BITS]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (out_kind),
        .out_ack     (out_ack),
        .out_data    (out_data),
        .out_last    (m_tlast),
        .mem_cmd     (mem_cmd),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data)
    );

    srr_slot_mem #(
        .WINDOW    (WINDOW),
        .DATA_BITS (DATA_BITS)
    ) u_mem (
        .clk     (clk),
        .cmd     (mem_cmd),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    assign m_tdata = TD_W'({out_data, out_ack});
    assign m_tuser = (out_kind == srr_pkg::KIND_DATA);

endmodule

@@ src/srr_checker.sv @@
// srr_checker: port-level assertions for selective_repeat_receiver_unit,
// attached by bind. Depends on srr_pkg.
module srr_checker #(
    parameter int SEQ_BITS  = srr_pkg::SEQ_BITS_DEF,
    parameter int DATA_BITS = srr_pkg::DATA_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((SEQ_BITS+DATA_BITS+7)/8)*8-1:0] m_tdata,
    input logic m_tuser,
    input logic m_tlast
);

    // output item holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output item changed while stalled");

    // one packet at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    a_data_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[SEQ_BITS-1:0] == '0)
        else $error("delivery item carries an ack number");

    a_ack_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[SEQ_BITS +: DATA_BITS] == '0)
        else $error("ack item carries payload");

    // an ack without last leaves while the block is still busy with the same packet
    a_ack_then_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tuser && !m_tlast |-> !s_tready)
        else $error("block idle after an unfinished ack");

endmodule

bind selective_repeat_receiver_unit srr_checker #(
    .SEQ_BITS  (SEQ_BITS),
    .DATA_BITS (DATA_BITS)
) u_srr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/srr_rx_checker.sv @@
// srr_rx_checker: watches both streams of the selective-repeat receiver, predicts its
// acks and in-order deliveries, and counts every mismatch. Depends on srr_pkg.
module srr_rx_checker #(
    parameter int WINDOW    = srr_pkg::WINDOW_DEF,
    parameter int SEQ_BITS  = srr_pkg::SEQ_BITS_DEF,
    parameter int DATA_BITS = srr_pkg::DATA_BITS_DEF,
    parameter int TDATA_W   = ((SEQ_BITS + DATA_BITS + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // seq_number, payload
    input  logic                s_tuser,   // checksum_ok
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [TDATA_W-1:0]  m_tdata,   // ack_number, data
    input  logic                m_tuser,   // kind
    input  logic                m_tlast,
    output int                  fail_count,
    output int                  pending,
    output logic [SEQ_BITS-1:0] rx_base
);

    typedef struct packed {
        srr_pkg::kind_t       kind;
        logic [SEQ_BITS-1:0]  ack_number;
        logic [DATA_BITS-1:0] data;
        logic                 last;
    } rx_item_t;

    rx_item_t             expected_q[$];
    logic [SEQ_BITS-1:0]  win_base;
    logic                 slot_full [WINDOW];
    logic [DATA_BITS-1:0] slot_data [WINDOW];
    int                   errors = 0;

    function automatic rx_item_t make_item(input srr_pkg::kind_t k,
                                           input logic [SEQ_BITS-1:0] ackn,
                                           input logic [DATA_BITS-1:0] word,
                                           input logic fin);
        rx_item_t it;
        it.kind       = k;
        it.ack_number = ackn;
        it.data       = word;
        it.last       = fin;
        return it;
    endfunction

    // good-checksum packet: update window and queue the items it must produce
    task automatic absorb_packet(input logic [SEQ_BITS-1:0] seq,
                                 input logic [DATA_BITS-1:0] pay);
        logic [SEQ_BITS-1:0] ahead;
        logic [SEQ_BITS-1:0] behind;
        int                  run;
        ahead  = seq - win_base;
        behind = win_base - seq;
        if (ahead < WINDOW) begin
            if (ahead != 0) begin
                slot_data[ahead] = pay;
                slot_full[ahead] = 1'b1;
                expected_q.push_back(make_item(srr_pkg::KIND_ACK, seq, '0, 1'b1));
            end else begin
                run = 1;
                while (run < WINDOW && slot_full[run])
                    run++;
                expected_q.push_back(make_item(srr_pkg::KIND_ACK, seq, '0, 1'b0));
                expected_q.push_back(make_item(srr_pkg::KIND_DATA, '0, pay, run == 1));
                for (int i = 1; i < run; i++)
                    expected_q.push_back(make_item(srr_pkg::KIND_DATA, '0, slot_data[i],
                                                   i == run - 1));
                for (int i = 0; i < WINDOW; i++) begin
                    if (i + run < WINDOW) begin
                        slot_full[i] = slot_full[i + run];
                        slot_data[i] = slot_data[i + run];
                    end else begin
                        slot_full[i] = 1'b0;
                    end
                end
                win_base = win_base + SEQ_BITS'(run);
            end
        end else if (behind >= 1 && behind <= WINDOW) begin
            expected_q.push_back(make_item(srr_pkg::KIND_ACK, seq, '0, 1'b1));
        end
    endtask

    always @(posedge clk) begin
        rx_item_t got;
        rx_item_t want;
        if (!rst_n) begin
            win_base = '0;
            for (int i = 0; i < WINDOW; i++) begin
                slot_full[i] = 1'b0;
                slot_data[i] = '0;
            end
            expected_q.delete();
        end else begin
            if (s_tvalid && s_tready && s_tuser)
                absorb_packet(s_tdata[SEQ_BITS-1:0], s_tdata[SEQ_BITS +: DATA_BITS]);
            if (m_tvalid && m_tready) begin
                got.kind       = srr_pkg::kind_t'(m_tuser);
                got.ack_number = m_tdata[SEQ_BITS-1:0];
                got.data       = m_tdata[SEQ_BITS +: DATA_BITS];
                got.last       = m_tlast;
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected item: kind=%0d ack=%0d data=%h last=%0d",
                                 got.kind, got.ack_number, got.data, got.last);
                end else begin
                    want = expected_q.pop_front();
                    if (got.kind !== want.kind || got.ack_number !== want.ack_number ||
                        got.data !== want.data || got.last !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp kind=%0d ack=%0d data=%h last=%0d, %s",
                                     want.kind, want.ack_number, want.data, want.last,
                                     $sformatf("got kind=%0d ack=%0d data=%h last=%0d",
                                               got.kind, got.ack_number, got.data,
                                               got.last));
                    end
                end
            end
        end
        fail_count <= errors;
        pending    <= expected_q.size();
        rx_base    <= win_base;
    end

endmodule

@@ tb/selective_repeat_receiver_unit_tb.sv @@
// selective_repeat_receiver_unit_tb: drives packets into the receiver with random gaps
// and output stalls; srr_rx_checker does the prediction. Depends on srr_pkg and the RTL.
module selective_repeat_receiver_unit_tb;

    localparam int WINDOW      = srr_pkg::WINDOW_DEF;
    localparam int SEQ_BITS    = srr_pkg::SEQ_BITS_DEF;
    localparam int DATA_BITS   = srr_pkg::DATA_BITS_DEF;
    localparam int TDATA_W     = ((SEQ_BITS + DATA_BITS + 7) / 8) * 8;
    localparam int PAD_BITS    = TDATA_W - SEQ_BITS - DATA_BITS;
    localparam int PACKETS     = 430;
    localparam int CYCLE_LIMIT = 1000000;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    int                  fail_count;
    int                  pending;
    logic [SEQ_BITS-1:0] rx_base;

    int                  cycles     = 0;
    int                  items_sent = 0;
    int                  stall_left = 0;
    int                  calm_timer = 0;
    logic                rx_calm    = 1'b0;
    logic                no_gaps    = 1'b0;

    selective_repeat_receiver_unit #(
        .WINDOW    (WINDOW),
        .SEQ_BITS  (SEQ_BITS),
        .DATA_BITS (DATA_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    srr_rx_checker #(
        .WINDOW    (WINDOW),
        .SEQ_BITS  (SEQ_BITS),
        .DATA_BITS (DATA_BITS)
    ) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending),
        .rx_base    (rx_base)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output backpressure: calm stretches alternate with random short and long stalls
    always @(posedge clk) begin
        int r;
        if (calm_timer == 0) begin
            rx_calm    <= ($urandom_range(0, 3) == 0);
            calm_timer <= $urandom_range(50, 300);
        end else begin
            calm_timer <= calm_timer - 1;
        end
        r = $urandom_range(0, 99);
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_calm || r < 70) begin
            m_tready <= 1'b1;
        end else if (r < 95) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(10, 40);
        end
    end

    function automatic logic [DATA_BITS-1:0] rand_word();
        return DATA_BITS'({$urandom, $urandom});
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_packet(input logic [SEQ_BITS-1:0] seq, input logic ok,
                               input logic [DATA_BITS-1:0] pay);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_BITS{1'b0}}, pay, seq};
        s_tuser  <= ok;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic rest();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        rest();
        while (pending != 0)
            @(posedge clk);
    endtask

    // one sender window sent out of order, with drops, resends and stale copies
    task automatic window_round();
        int                  n;
        int                  k;
        int                  tmp;
        int                  order [WINDOW];
        int                  lost [$];
        logic [SEQ_BITS-1:0] start;
        logic                ok;
        start = rx_base;
        n = ($urandom_range(0, 3) == 0) ? WINDOW : $urandom_range(1, WINDOW);
        for (int j = 0; j < n; j++)
            order[j] = j;
        for (int j = n - 1; j > 0; j--) begin
            k        = $urandom_range(0, j);
            tmp      = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        for (int j = 0; j < n; j++) begin
            ok = ($urandom_range(0, 9) != 0);
            send_packet(start + SEQ_BITS'(order[j]), ok, rand_word());
            if (!ok)
                lost.push_back(order[j]);
            if ($urandom_range(0, 9) == 0)
                send_packet(start + SEQ_BITS'(order[$urandom_range(0, j)]), 1'b1,
                            rand_word());
            else if ($urandom_range(0, 14) == 0)
                send_packet(start - SEQ_BITS'($urandom_range(1, WINDOW)), 1'b1,
                            rand_word());
        end
        foreach (lost[i])
            send_packet(start + SEQ_BITS'(lost[i]), 1'b1, rand_word());
    endtask

    task automatic noise_round();
        int n;
        n = $urandom_range(1, 6);
        for (int j = 0; j < n; j++)
            send_packet(SEQ_BITS'($urandom), 1'(($urandom_range(0, 1))), rand_word());
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window base 0: drop, buffer at both ends, stale acks, overwrite, short delivery
        send_packet(SEQ_BITS'(0), 1'b0, {DATA_BITS{1'b1}});
        send_packet(SEQ_BITS'(1), 1'b1, {DATA_BITS{1'b1}});
        send_packet(SEQ_BITS'(7), 1'b1, {(DATA_BITS / 2){2'b01}});
        send_packet(SEQ_BITS'(8), 1'b1, rand_word());
        send_packet(SEQ_BITS'(1), 1'b1, {(DATA_BITS / 2){2'b10}});
        send_packet(SEQ_BITS'(15), 1'b1, rand_word());
        send_packet(SEQ_BITS'(0), 1'b1, '0);
        // base 2: fill up to 8, then release the run of seven
        for (int s = 3; s <= 8; s++)
            if (s != 7)
                send_packet(SEQ_BITS'(s), 1'b1, rand_word());
        send_packet(SEQ_BITS'(2), 1'b1, rand_word());
        // base 9: fill the whole window ahead of the base, then the longest delivery
        for (int s = 10; s <= 16; s++)
            send_packet(SEQ_BITS'(s), 1'b1, rand_word());
        send_packet(SEQ_BITS'(9), 1'b1, {DATA_BITS{1'b1}});
        // base 1: previous window edges, dropped in-window packet, lone delivery
        send_packet(SEQ_BITS'(0), 1'b1, rand_word());
        send_packet(SEQ_BITS'(9), 1'b1, rand_word());
        send_packet(SEQ_BITS'(5), 1'b0, rand_word());
        send_packet(SEQ_BITS'(1), 1'b1, '0);
        wait_drained();

        while (items_sent < PACKETS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 6) == 0)
                noise_round();
            else
                window_round();
            rest();
            if ($urandom_range(0, 29) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
